### rtl/core/wavhp_pkg.sv
// Shared types and constants for the WAV PCM header parser.
// Used by every module under rtl/core; depends on nothing else.
package wavhp_pkg;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       start_of_file;
   } wavhp_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  error_code;
      logic [1:0]  channel_count;
      logic [31:0] rate_hz;
      logic [4:0]  sample_bits;
      logic [31:0] payload_size;
      logic [7:0]  payload_byte;
      logic        last;
   } wavhp_rsp_type;

   // Parser phases.
   localparam logic [1:0] PHASE_HEADER  = 2'd0;
   localparam logic [1:0] PHASE_BADMARK = 2'd1;
   localparam logic [1:0] PHASE_PAYLOAD = 2'd2;
   localparam logic [1:0] PHASE_DONE    = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_MARK     = 3'd0;
   localparam logic [2:0] ERR_FORMAT   = 3'd1;
   localparam logic [2:0] ERR_CHANNELS = 3'd2;
   localparam logic [2:0] ERR_BITS     = 3'd3;
   localparam logic [2:0] ERR_DATA     = 3'd4;

   // Header byte offsets at which a field or mark is complete.
   localparam logic [5:0] OFS_RIFF     = 6'd3;
   localparam logic [5:0] OFS_WAVE     = 6'd11;
   localparam logic [5:0] OFS_FMT      = 6'd15;
   localparam logic [5:0] OFS_FMT_SIZE = 6'd19;
   localparam logic [5:0] OFS_FORMAT   = 6'd21;
   localparam logic [5:0] OFS_CHANNELS = 6'd23;
   localparam logic [5:0] OFS_RATE     = 6'd27;
   localparam logic [5:0] OFS_BITS     = 6'd35;
   localparam logic [5:0] OFS_DATA     = 6'd39;
   localparam logic [5:0] OFS_SIZE     = 6'd43;

   // Four-byte marks in both byte orders.
   localparam logic [31:0] MARK_RIFF_A = 32'h52494646;
   localparam logic [31:0] MARK_RIFF_B = 32'h46464952;
   localparam logic [31:0] MARK_WAVE_A = 32'h57415645;
   localparam logic [31:0] MARK_WAVE_B = 32'h45564157;
   localparam logic [31:0] MARK_FMT_A  = 32'h666d7420;
   localparam logic [31:0] MARK_FMT_B  = 32'h20746d66;
   localparam logic [31:0] MARK_DATA_A = 32'h64617461;
   localparam logic [31:0] MARK_DATA_B = 32'h61746164;

   localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
   localparam logic [15:0] FMT_PCM        = 16'd1;
   localparam logic [15:0] BITS_8         = 16'd8;
   localparam logic [15:0] BITS_16        = 16'd16;

   localparam int QUEUE_DEPTH = 2;

endpackage

### rtl/core/wavhp_front.sv
// Front end of the WAV parser: takes bytes, walks the header and builds results.
// Depends on wavhp_pkg.
module wavhp_front import wavhp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  wavhp_req_type req,
   output logic          push_valid,
   output wavhp_rsp_type push_data,
   input  logic          push_space
);

   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  offset_ff, offset_in;
   logic [31:0] shift_ff, shift_in;
   logic [1:0]  chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [4:0]  bits_ff, bits_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] left_ff, left_in;

   logic        accept;
   logic [1:0]  cur_phase;
   logic [5:0]  cur_offset;
   logic [31:0] cur_shift;
   logic [31:0] new_shift;
   logic [15:0] upper;
   logic [31:0] left_dec;

   assign req_ready = push_space;
   assign accept    = req_valid & push_space;

   always_comb begin
      // A start-of-file byte restarts the parse with this byte as header byte 0.
      cur_phase  = req.start_of_file ? PHASE_HEADER : phase_ff;
      cur_offset = req.start_of_file ? 6'd0 : offset_ff;
      cur_shift  = req.start_of_file ? 32'd0 : shift_ff;
      new_shift  = {req.byte_value, cur_shift[31:8]};
      upper      = new_shift[31:16];
      left_dec   = left_ff - 32'd1;

      phase_in   = phase_ff;
      offset_in  = offset_ff;
      shift_in   = shift_ff;
      chan_in    = chan_ff;
      rate_in    = rate_ff;
      bits_in    = bits_ff;
      size_in    = size_ff;
      left_in    = left_ff;
      push_valid = 1'b0;
      push_data  = '0;

      if (accept) begin
         phase_in  = cur_phase;
         offset_in = cur_offset;
         shift_in  = cur_shift;
         case (cur_phase)
            PHASE_DONE: begin
            end
            PHASE_PAYLOAD: begin
               if (left_ff == 32'd0) begin
                  phase_in = PHASE_DONE;
               end else begin
                  left_in                = left_dec;
                  push_valid             = 1'b1;
                  push_data.kind         = KIND_PAYLOAD;
                  push_data.payload_byte = req.byte_value;
                  push_data.last         = (left_dec == 32'd0);
                  if (left_dec == 32'd0) begin
                     phase_in = PHASE_DONE;
                  end
               end
            end
            default: begin
               shift_in  = new_shift;
               offset_in = cur_offset + 6'd1;
               case (cur_offset)
                  OFS_RIFF: begin
                     if (new_shift != MARK_RIFF_A && new_shift != MARK_RIFF_B) begin
                        phase_in = PHASE_BADMARK;
                     end
                  end
                  OFS_WAVE: begin
                     if (new_shift != MARK_WAVE_A && new_shift != MARK_WAVE_B) begin
                        phase_in = PHASE_BADMARK;
                     end
                  end
                  OFS_FMT: begin
                     if ((new_shift != MARK_FMT_A && new_shift != MARK_FMT_B) ||
                         cur_phase == PHASE_BADMARK) begin
                        push_valid           = 1'b1;
                        push_data.kind       = KIND_ERROR;
                        push_data.error_code = ERR_MARK;
                        push_data.last       = 1'b1;
                        phase_in             = PHASE_DONE;
                     end
                  end
                  OFS_FMT_SIZE: begin
                     size_in = new_shift;
                  end
                  OFS_FORMAT: begin
                     if (size_ff != FMT_CHUNK_SIZE || upper != FMT_PCM) begin
                        push_valid           = 1'b1;
                        push_data.kind       = KIND_ERROR;
                        push_data.error_code = ERR_FORMAT;
                        push_data.last       = 1'b1;
                        phase_in             = PHASE_DONE;
                     end
                  end
                  OFS_CHANNELS: begin
                     if (upper != 16'd1 && upper != 16'd2) begin
                        push_valid           = 1'b1;
                        push_data.kind       = KIND_ERROR;
                        push_data.error_code = ERR_CHANNELS;
                        push_data.last       = 1'b1;
                        phase_in             = PHASE_DONE;
                     end else begin
                        chan_in = upper[1:0];
                     end
                  end
                  OFS_RATE: begin
                     rate_in = new_shift;
                  end
                  OFS_BITS: begin
                     if (upper != BITS_8 && upper != BITS_16) begin
                        push_valid           = 1'b1;
                        push_data.kind       = KIND_ERROR;
                        push_data.error_code = ERR_BITS;
                        push_data.last       = 1'b1;
                        phase_in             = PHASE_DONE;
                     end else begin
                        bits_in = upper[4:0];
                     end
                  end
                  OFS_DATA: begin
                     if (new_shift != MARK_DATA_A && new_shift != MARK_DATA_B) begin
                        push_valid           = 1'b1;
                        push_data.kind       = KIND_ERROR;
                        push_data.error_code = ERR_DATA;
                        push_data.last       = 1'b1;
                        phase_in             = PHASE_DONE;
                     end
                  end
                  OFS_SIZE: begin
                     size_in                 = new_shift;
                     left_in                 = new_shift;
                     push_valid              = 1'b1;
                     push_data.kind          = KIND_HEADER;
                     push_data.channel_count = chan_ff;
                     push_data.rate_hz       = rate_ff;
                     push_data.sample_bits   = bits_ff;
                     push_data.payload_size  = new_shift;
                     push_data.last          = (new_shift == 32'd0);
                     phase_in = (new_shift == 32'd0) ? PHASE_DONE : PHASE_PAYLOAD;
                  end
                  default: begin
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HEADER;
         offset_ff <= 6'd0;
         shift_ff  <= 32'd0;
         chan_ff   <= 2'd0;
         rate_ff   <= 32'd0;
         bits_ff   <= 5'd0;
         size_ff   <= 32'd0;
         left_ff   <= 32'd0;
      end else begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         shift_ff  <= shift_in;
         chan_ff   <= chan_in;
         rate_ff   <= rate_in;
         bits_ff   <= bits_in;
         size_ff   <= size_in;
         left_ff   <= left_in;
      end
   end

endmodule

### rtl/core/wavhp_queue.sv
// Two-entry result queue between the parser front end and the output stage.
// Depends on wavhp_pkg.
module wavhp_queue import wavhp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  wavhp_rsp_type push_data,
   output logic          push_space,
   output logic          pop_valid,
   output wavhp_rsp_type pop_data,
   input  logic          pop
);

   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   wavhp_rsp_type                entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]          count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign push_space = (count_ff != CntWidth'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_space;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/wavhp_back.sv
// Output stage of the WAV parser: registers one result toward the consumer.
// Depends on wavhp_pkg.
module wavhp_back import wavhp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   input  wavhp_rsp_type pop_data,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output wavhp_rsp_type rsp
);

   logic          valid_ff, valid_in;
   wavhp_rsp_type data_ff;

   // The register refills whenever the queue holds a result and the register is empty or its transaction completes.
   assign pop      = pop_valid & (~valid_ff | rsp_ready);
   assign valid_in = pop | (valid_ff & ~rsp_ready);

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= pop_data;
      end
   end

endmodule

### rtl/core/wav_pcm_header_parser.sv
// Top level of the WAV PCM header parser: front end, result queue, output stage.
// Depends on wavhp_pkg, wavhp_front, wavhp_queue and wavhp_back.
//
//   Channel   Ports                               Payload
//   input     req_valid, req_ready, req_data      one file byte and start-of-file flag
//   result    rsp_valid, rsp_ready, rsp_data      descriptor, payload byte or error
//
// One byte is taken per cycle while req_ready is high; a result from a byte passes
// through the two-entry queue and then the output register to rsp_data.
// Reset returns the parser to header byte 0 and empties the queue and output.
// A stalled consumer fills the queue; req_ready then drops, and it depends only
// on the queue fill count, not on rsp_ready.
module wav_pcm_header_parser import wavhp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  wavhp_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output wavhp_rsp_type rsp_data
);

   logic          push_valid;
   logic          push_space;
   wavhp_rsp_type push_data;
   logic          pop_valid;
   logic          pop;
   wavhp_rsp_type pop_data;

   wavhp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_space (push_space)
   );

   wavhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_space (push_space),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop)
   );

   wavhp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

endmodule

### tb/tb_wav_pcm_header_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for wav_pcm_header_parser: feeds WAV byte streams and compares
// every result transaction against a behavioral parser kept alongside the stimulus.
// Depends on wavhp_pkg and the wav_pcm_header_parser RTL only.
module tb_wav_pcm_header_parser;
   import wavhp_pkg::*;

   // Canonical 44-byte header, first byte of the file in the least significant bits.
   typedef struct packed {
      logic [31:0] chunk_len;
      logic [31:0] data_mark;
      logic [15:0] bits;
      logic [15:0] align;
      logic [31:0] byte_rate;
      logic [31:0] rate;
      logic [15:0] channels;
      logic [15:0] format;
      logic [31:0] fmt_size;
      logic [31:0] fmt;
      logic [31:0] wave;
      logic [31:0] riff_len;
      logic [31:0] riff;
   } wav_header_type;

   typedef enum int {
      FLAW_RIFF, FLAW_WAVE, FLAW_FMT, FLAW_FMT_SIZE,
      FLAW_FORMAT, FLAW_CHANNELS, FLAW_BITS, FLAW_DATA
   } header_flaw_type;

   localparam int ITEM_TARGET = 1650;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   wavhp_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   wavhp_rsp_type rsp_data;

   // Behavioral parser state.
   logic [1:0]  model_phase    = PHASE_HEADER;
   logic [5:0]  model_offset   = '0;
   logic [31:0] model_shift    = '0;
   logic [1:0]  model_channels = '0;
   logic [31:0] model_rate     = '0;
   logic [4:0]  model_bits     = '0;
   logic [31:0] model_size     = '0;
   logic [31:0] model_left     = '0;

   wavhp_rsp_type wav_results_due[$];

   bit          req_idle_on = 1'b0;
   bit          rsp_idle_on = 1'b0;
   int unsigned rsp_hold_request = 0;
   int unsigned mismatch_count = 0;
   int unsigned parsed_bytes = 0;
   int unsigned bytes_sent = 0;
   int unsigned files_sent = 0;
   int unsigned results_seen = 0;
   int unsigned descriptors_seen = 0;
   int unsigned errors_seen = 0;
   int unsigned input_stalls = 0;

   wav_pcm_header_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready)
         input_stalls++;
   end

   function automatic int unsigned draw_wait(input bit enabled);
      return enabled ? $urandom_range(0, 19) : 0;
   endfunction

   function automatic bit is_mark(input logic [31:0] v, input logic [31:0] a,
                                  input logic [31:0] b);
      return v == a || v == b;
   endfunction

   task automatic queue_error(input logic [2:0] code);
      wavhp_rsp_type res;
      res = '0;
      res.kind = KIND_ERROR;
      res.error_code = code;
      res.last = 1'b1;
      model_phase = PHASE_DONE;
      wav_results_due.insert(wav_results_due.size(), res);
   endtask

   // Advances the behavioral parser by one accepted byte and queues its result, if any.
   task automatic parse_wav_byte(input wavhp_req_type r);
      wavhp_rsp_type res;
      logic [5:0]    ofs;
      logic [15:0]   upper;
      res = '0;
      if (r.start_of_file) begin
         model_phase = PHASE_HEADER;
         model_offset = '0;
         model_shift = '0;
      end
      if (model_phase == PHASE_DONE)
         return;
      parsed_bytes++;
      if (model_phase == PHASE_PAYLOAD) begin
         if (model_left == 0) begin
            model_phase = PHASE_DONE;
            return;
         end
         model_left--;
         res.kind = KIND_PAYLOAD;
         res.payload_byte = r.byte_value;
         res.last = (model_left == 0);
         if (model_left == 0)
            model_phase = PHASE_DONE;
         wav_results_due.insert(wav_results_due.size(), res);
         return;
      end
      model_shift = {r.byte_value, model_shift[31:8]};
      ofs = model_offset;
      model_offset = model_offset + 6'd1;
      upper = model_shift[31:16];
      case (ofs)
         OFS_RIFF: begin
            if (!is_mark(model_shift, MARK_RIFF_A, MARK_RIFF_B))
               model_phase = PHASE_BADMARK;
         end
         OFS_WAVE: begin
            if (!is_mark(model_shift, MARK_WAVE_A, MARK_WAVE_B))
               model_phase = PHASE_BADMARK;
         end
         OFS_FMT: begin
            // An earlier bad mark is only reported once the fmt mark is complete.
            if (!is_mark(model_shift, MARK_FMT_A, MARK_FMT_B) || model_phase == PHASE_BADMARK)
               queue_error(ERR_MARK);
         end
         OFS_FMT_SIZE: model_size = model_shift;
         OFS_FORMAT: begin
            if (model_size != FMT_CHUNK_SIZE || upper != FMT_PCM)
               queue_error(ERR_FORMAT);
         end
         OFS_CHANNELS: begin
            if (upper != 16'd1 && upper != 16'd2)
               queue_error(ERR_CHANNELS);
            else
               model_channels = upper[1:0];
         end
         OFS_RATE: model_rate = model_shift;
         OFS_BITS: begin
            if (upper != BITS_8 && upper != BITS_16)
               queue_error(ERR_BITS);
            else
               model_bits = upper[4:0];
         end
         OFS_DATA: begin
            if (!is_mark(model_shift, MARK_DATA_A, MARK_DATA_B))
               queue_error(ERR_DATA);
         end
         OFS_SIZE: begin
            model_size = model_shift;
            model_left = model_shift;
            res.kind = KIND_HEADER;
            res.channel_count = model_channels;
            res.rate_hz = model_rate;
            res.sample_bits = model_bits;
            res.payload_size = model_size;
            res.last = (model_size == 0);
            model_phase = (model_size == 0) ? PHASE_DONE : PHASE_PAYLOAD;
            wav_results_due.insert(wav_results_due.size(), res);
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40)
         $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_result(input wavhp_rsp_type got);
      wavhp_rsp_type want;
      results_seen++;
      if (got.kind == KIND_HEADER)
         descriptors_seen++;
      if (got.kind == KIND_ERROR)
         errors_seen++;
      if (wav_results_due.size() == 0) begin
         report_mismatch($sformatf("result with nothing due, kind %0d", got.kind));
         return;
      end
      want = wav_results_due.pop_front();
      if (got.kind !== want.kind)
         report_mismatch($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
      if (got.error_code !== want.error_code)
         report_mismatch($sformatf("error_code %0d, wanted %0d", got.error_code,
                                   want.error_code));
      if (got.channel_count !== want.channel_count)
         report_mismatch($sformatf("channel_count %0d, wanted %0d", got.channel_count,
                                   want.channel_count));
      if (got.rate_hz !== want.rate_hz)
         report_mismatch($sformatf("rate_hz %h, wanted %h", got.rate_hz,
                                   want.rate_hz));
      if (got.sample_bits !== want.sample_bits)
         report_mismatch($sformatf("sample_bits %0d, wanted %0d", got.sample_bits,
                                   want.sample_bits));
      if (got.payload_size !== want.payload_size)
         report_mismatch($sformatf("payload_size %h, wanted %h", got.payload_size,
                                   want.payload_size));
      if (got.payload_byte !== want.payload_byte)
         report_mismatch($sformatf("payload_byte %h, wanted %h", got.payload_byte,
                                   want.payload_byte));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
   endtask

   // Offers one byte after a random gap and returns on the edge where it is accepted.
   // Valid stays high on return so that a back-to-back transaction needs no toggle.
   task automatic send_byte(input logic [7:0] value, input bit sof);
      int unsigned   gap;
      wavhp_req_type item;
      gap = draw_wait(req_idle_on);
      item.byte_value = value;
      item.start_of_file = sof;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      bytes_sent++;
      parse_wav_byte(item);
   endtask

   task automatic send_file(input wav_header_type h, input int unsigned n_payload,
                            input bit sof);
      logic [351:0] image;
      image = h;
      for (int i = 0; i < 44; i++)
         send_byte(image[8*i +: 8], sof && i == 0);
      for (int i = 0; i < n_payload; i++)
         send_byte(8'($urandom()), 1'b0);
      files_sent++;
   endtask

   // Drops valid and waits until every queued result has come back.
   task automatic settle_results();
      req_valid <= 1'b0;
      while (wav_results_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic wav_header_type valid_header(input logic [31:0] size);
      wav_header_type h;
      h.riff = $urandom_range(0, 1) ? MARK_RIFF_A : MARK_RIFF_B;
      h.riff_len = $urandom();
      h.wave = $urandom_range(0, 1) ? MARK_WAVE_A : MARK_WAVE_B;
      h.fmt = $urandom_range(0, 1) ? MARK_FMT_A : MARK_FMT_B;
      h.fmt_size = FMT_CHUNK_SIZE;
      h.format = FMT_PCM;
      h.channels = 16'($urandom_range(1, 2));
      case ($urandom_range(0, 7))
         0: h.rate = '0;
         1: h.rate = '1;
         default: h.rate = $urandom();
      endcase
      h.byte_rate = $urandom();
      h.align = 16'($urandom());
      h.bits = $urandom_range(0, 1) ? BITS_8 : BITS_16;
      h.data_mark = $urandom_range(0, 1) ? MARK_DATA_A : MARK_DATA_B;
      h.chunk_len = size;
      return h;
   endfunction

   function automatic wav_header_type corrupt_header(input wav_header_type h,
                                                     input header_flaw_type flaw);
      wav_header_type bad;
      bad = h;
      case (flaw)
         FLAW_RIFF: bad.riff = $urandom();
         FLAW_WAVE: bad.wave = $urandom();
         FLAW_FMT: bad.fmt = $urandom();
         FLAW_FMT_SIZE: bad.fmt_size = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom();
         FLAW_FORMAT:
            bad.format = 16'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom());
         FLAW_CHANNELS: begin
            case ($urandom_range(0, 2))
               0: bad.channels = 16'd0;
               1: bad.channels = 16'd3;
               default: bad.channels = 16'($urandom());
            endcase
         end
         FLAW_BITS: begin
            case ($urandom_range(0, 3))
               0: bad.bits = 16'd0;
               1: bad.bits = 16'd7;
               2: bad.bits = 16'd24;
               default: bad.bits = 16'($urandom());
            endcase
         end
         FLAW_DATA: bad.data_mark = $urandom();
         default: ;
      endcase
      return bad;
   endfunction

   // Parsing must begin at reset even when the first byte lacks the start flag.
   task automatic test_start_without_flag();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_file(valid_header(3), 3, 1'b0);
      settle_results();
   endtask

   task automatic test_mark_byte_orders();
      wav_header_type h;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      h = valid_header(1);
      h.riff = MARK_RIFF_A;
      h.wave = MARK_WAVE_A;
      h.fmt = MARK_FMT_A;
      h.data_mark = MARK_DATA_A;
      send_file(h, 1, 1'b1);
      h.riff = MARK_RIFF_B;
      h.wave = MARK_WAVE_B;
      h.fmt = MARK_FMT_B;
      h.data_mark = MARK_DATA_B;
      send_file(h, 1, 1'b1);
      h.riff = MARK_RIFF_A;
      h.fmt = MARK_FMT_A;
      send_file(h, 1, 1'b1);
      settle_results();
   endtask

   // Each flaw is injected once; trailing bytes after an error must stay silent.
   task automatic test_header_errors();
      wav_header_type h;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      for (int f = FLAW_RIFF; f <= FLAW_DATA; f++) begin
         h = corrupt_header(valid_header(2), header_flaw_type'(f));
         send_file(h, 3, 1'b1);
      end
      // A bad RIFF mark together with a bad fmt mark still reports a single mark error.
      h = corrupt_header(corrupt_header(valid_header(2), FLAW_RIFF), FLAW_FMT);
      send_file(h, 2, 1'b1);
      settle_results();
   endtask

   task automatic test_field_extremes();
      wav_header_type h;
      logic [351:0]   image;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b0;
      // Empty payload: the descriptor alone closes the file.
      h = valid_header(0);
      h.rate = '0;
      h.channels = 16'd1;
      h.bits = BITS_8;
      send_file(h, 3, 1'b1);
      h = valid_header(2);
      h.rate = '1;
      h.channels = 16'd2;
      h.bits = BITS_16;
      h.riff_len = '1;
      h.byte_rate = '1;
      h.align = '1;
      send_file(h, 0, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b0);
      // A huge data size is cut short by a new file.
      send_file(valid_header('1), 5, 1'b1);
      // Restart in the middle of a header.
      image = valid_header(4);
      for (int i = 0; i < 20; i++)
         send_byte(image[8*i +: 8], i == 0);
      send_file(valid_header(4), 4, 1'b1);
      settle_results();
   endtask

   // The sink holds off for a long stretch while bytes keep coming, so the input stalls.
   task automatic test_back_pressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_hold_request = 300;
      send_file(valid_header(60), 60, 1'b1);
      settle_results();
      rsp_idle_on = 1'b1;
      send_file(valid_header(8), 8, 1'b1);
      settle_results();
   endtask

   task automatic test_random_files();
      wav_header_type h;
      logic [351:0]   raw;
      logic [31:0]    size;
      int unsigned    n_payload;
      bit             sof;
      while (bytes_sent < ITEM_TARGET) begin
         req_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on = $urandom_range(0, 3) != 0;
         // Occasional stray bytes between files.
         if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom()), $urandom_range(0, 3) == 0);
         end
         size = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
         h = valid_header(size);
         n_payload = size;
         sof = 1'b1;
         case ($urandom_range(0, 15))
            0, 1, 2:
               h = corrupt_header(h, header_flaw_type'($urandom_range(FLAW_RIFF, FLAW_DATA)));
            3: begin
               raw = h;
               raw[8*$urandom_range(0, 43) +: 8] = 8'($urandom());
               h = raw;
            end
            4: sof = 1'b0;
            5: n_payload = $urandom_range(0, size);
            6: n_payload = size + $urandom_range(1, 4);
            7: begin
               h.chunk_len = $urandom();
               n_payload = $urandom_range(0, 6);
            end
            default: ;
         endcase
         send_file(h, n_payload, sof);
         if ($urandom_range(0, 9) == 0)
            settle_results();
      end
   endtask

   initial begin : result_sink
      int unsigned stall;
      bit          took;
      took = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_request != 0) begin
            stall = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (took) begin
            stall = draw_wait(rsp_idle_on);
         end else begin
            stall = 0;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         took = (rsp_valid === 1'b1) && !reset;
         if (took)
            check_result(rsp_data);
      end
   end

   initial begin : watchdog
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : test_sequence
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_start_without_flag();
      test_mark_byte_orders();
      test_header_errors();
      test_field_extremes();
      test_back_pressure();
      test_random_files();
      settle_results();
      repeat (8) @(posedge clock);
      $display("Sent %0d files in %0d bytes, %0d bytes parsed; %0d results checked",
               files_sent, bytes_sent, parsed_bytes, results_seen);
      $display("(%0d descriptors, %0d errors), input stalled for %0d cycles.",
               descriptors_seen, errors_seen, input_stalls);
      if (mismatch_count == 0 && wav_results_due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
